>>> src/qip_pkg.sv
`default_nettype none

package qip_pkg;

	// Pipeline depth: products, Montgomery quotient and fold for each of four rounds.
	localparam int NumStages = 12;

	localparam logic signed [15:0] ModQ       = 16'sd3457;
	// Low 16 bits of -q^-1 mod 2^16 (-12929).
	localparam logic [15:0]        NegQinvLo  = 16'hCD7F;

	typedef logic signed [15:0] coef_t;

	typedef struct packed {
		logic [NumStages-1:0] en;
		logic                 out_valid;
	} pipe_ctl_t;

	// Exact signed 16x16 product, returned as a 32-bit word for wrapping sums.
	function automatic logic [31:0] mul16(input coef_t a, input coef_t b);
		logic signed [31:0] p;
		p = 32'(a) * 32'(b);
		return p;
	endfunction

	// First half of the reduction: quotient digit m = low16(x) * -q^-1 mod 2^16.
	function automatic logic [15:0] mred_quot(input logic [31:0] x);
		logic [15:0] m;
		m = x[15:0] * NegQinvLo;
		return m;
	endfunction

	// Second half: (x + s16(m) * q) >> 16, read as signed 16 bit.
	function automatic coef_t mred_fold(input logic [31:0] x, input logic [15:0] m);
		logic signed [31:0] c;
		logic [31:0]        s;
		c = 32'($signed(m)) * 32'(ModQ);
		s = x + c;
		return s[31:16];
	endfunction

	// -2*v modulo 2^16.
	function automatic coef_t negdbl16(input coef_t v);
		logic [15:0] r;
		r = 16'd0 - {v[14:0], 1'b0};
		return r;
	endfunction

	// -v modulo 2^16.
	function automatic coef_t neg16(input coef_t v);
		logic [15:0] r;
		r = 16'd0 - v;
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/qip_flow.sv
`default_nettype none

module qip_flow (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              out_stall,
	output logic                   in_stall,
	output qip_pkg::pipe_ctl_t     ctl
);
	import qip_pkg::*;

	logic [NumStages-1:0] vld_q;
	logic [NumStages-1:0] en;

	// A stage loads when it is empty or when the stage after it moves on,
	// so bubbles collapse even while the output word is held.
	always_comb begin
		en[NumStages-1] = !vld_q[NumStages-1] || !out_stall;
		for (int k = NumStages - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NumStages; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_stall      = !en[0];
	assign ctl.en        = en;
	assign ctl.out_valid = vld_q[NumStages-1];

endmodule

`default_nettype wire

>>> src/quartic_inverse_prepare.sv
// Throughput: one word per cycle unless a held output has filled every stage;
// each of the four Montgomery rounds takes three stages (products and sums,
// quotient digit, fold).
// A held output does not block input until all twelve stages are full.
// Reset clears only the stage valid bits; the datapath registers are not reset.
`default_nettype none

module quartic_inverse_prepare (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire qip_pkg::coef_t       coef_in_0,
	input  wire qip_pkg::coef_t       coef_in_1,
	input  wire qip_pkg::coef_t       coef_in_2,
	input  wire qip_pkg::coef_t       coef_in_3,
	input  wire qip_pkg::coef_t       twist,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output qip_pkg::coef_t            numer_0,
	output qip_pkg::coef_t            numer_1,
	output qip_pkg::coef_t            numer_2,
	output qip_pkg::coef_t            numer_3,
	output qip_pkg::coef_t            denominator
);
	import qip_pkg::*;

	pipe_ctl_t ctl;

	qip_flow u_flow (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.ctl       (ctl)
	);

	// Round 1: M(a2*a2 - 2*a1*a3) and M(a3*a3); a0*a0 and a1*a1 - 2*a0*a2 ride along.
	coef_t       a_s1 [4];
	coef_t       z_s1;
	logic [31:0] p_s1 [4];
	coef_t       a_s2 [4];
	coef_t       z_s2;
	logic [31:0] p_s2 [4];
	logic [15:0] m_s2 [2];
	coef_t       a_s3 [4];
	coef_t       z_s3;
	logic [31:0] p_s3 [2];
	coef_t       u_s3 [2];
	// Round 2: t0 and t1.
	coef_t       a_s4 [4];
	coef_t       z_s4;
	logic [31:0] q_s4 [2];
	coef_t       a_s5 [4];
	coef_t       z_s5;
	logic [31:0] q_s5 [2];
	logic [15:0] m_s5 [2];
	coef_t       a_s6 [4];
	coef_t       z_s6;
	coef_t       t_s6 [2];
	// Round 3: t2.
	coef_t       a_s7 [4];
	coef_t       t_s7 [2];
	logic [31:0] r_s7;
	coef_t       a_s8 [4];
	coef_t       t_s8 [2];
	logic [31:0] r_s8;
	logic [15:0] m_s8;
	coef_t       a_s9 [4];
	coef_t       t_s9 [3];
	// Round 4: numerator coefficients 0..3 and the denominator at index 4.
	logic [31:0] d_s10 [5];
	logic [31:0] d_s11 [5];
	logic [15:0] m_s11 [5];
	coef_t       res_s12 [5];

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			a_s1[0] <= coef_in_0;
			a_s1[1] <= coef_in_1;
			a_s1[2] <= coef_in_2;
			a_s1[3] <= coef_in_3;
			z_s1    <= twist;
			p_s1[0] <= mul16(coef_in_2, coef_in_2) + mul16(coef_in_1, negdbl16(coef_in_3));
			p_s1[1] <= mul16(coef_in_3, coef_in_3);
			p_s1[2] <= mul16(coef_in_0, coef_in_0);
			p_s1[3] <= mul16(coef_in_1, coef_in_1) + mul16(coef_in_0, negdbl16(coef_in_2));
		end
		if (ctl.en[1]) begin
			a_s2    <= a_s1;
			z_s2    <= z_s1;
			p_s2    <= p_s1;
			m_s2[0] <= mred_quot(p_s1[0]);
			m_s2[1] <= mred_quot(p_s1[1]);
		end
		if (ctl.en[2]) begin
			a_s3    <= a_s2;
			z_s3    <= z_s2;
			p_s3[0] <= p_s2[2];
			p_s3[1] <= p_s2[3];
			u_s3[0] <= mred_fold(p_s2[0], m_s2[0]);
			u_s3[1] <= mred_fold(p_s2[1], m_s2[1]);
		end
		if (ctl.en[3]) begin
			a_s4    <= a_s3;
			z_s4    <= z_s3;
			q_s4[0] <= mul16(u_s3[0], z_s3) + p_s3[0];
			q_s4[1] <= mul16(u_s3[1], z_s3) + p_s3[1];
		end
		if (ctl.en[4]) begin
			a_s5    <= a_s4;
			z_s5    <= z_s4;
			q_s5    <= q_s4;
			m_s5[0] <= mred_quot(q_s4[0]);
			m_s5[1] <= mred_quot(q_s4[1]);
		end
		if (ctl.en[5]) begin
			a_s6    <= a_s5;
			z_s6    <= z_s5;
			t_s6[0] <= mred_fold(q_s5[0], m_s5[0]);
			t_s6[1] <= mred_fold(q_s5[1], m_s5[1]);
		end
		if (ctl.en[6]) begin
			a_s7 <= a_s6;
			t_s7 <= t_s6;
			r_s7 <= mul16(t_s6[1], z_s6);
		end
		if (ctl.en[7]) begin
			a_s8 <= a_s7;
			t_s8 <= t_s7;
			r_s8 <= r_s7;
			m_s8 <= mred_quot(r_s7);
		end
		if (ctl.en[8]) begin
			a_s9    <= a_s8;
			t_s9[0] <= t_s8[0];
			t_s9[1] <= t_s8[1];
			t_s9[2] <= mred_fold(r_s8, m_s8);
		end
		if (ctl.en[9]) begin
			d_s10[0] <= mul16(a_s9[0], t_s9[0]) + mul16(a_s9[2], t_s9[2]);
			d_s10[1] <= mul16(a_s9[3], t_s9[2]) + mul16(a_s9[1], t_s9[0]);
			d_s10[2] <= mul16(a_s9[2], t_s9[0]) + mul16(a_s9[0], t_s9[1]);
			d_s10[3] <= mul16(a_s9[1], t_s9[1]) + mul16(a_s9[3], t_s9[0]);
			d_s10[4] <= mul16(t_s9[0], t_s9[0]) + mul16(neg16(t_s9[1]), t_s9[2]);
		end
		if (ctl.en[10]) begin
			d_s11 <= d_s10;
			for (int k = 0; k < 5; k++) begin
				m_s11[k] <= mred_quot(d_s10[k]);
			end
		end
		if (ctl.en[11]) begin
			for (int k = 0; k < 5; k++) begin
				res_s12[k] <= mred_fold(d_s11[k], m_s11[k]);
			end
		end
	end

	assign out_valid   = ctl.out_valid;
	assign numer_0     = res_s12[0];
	assign numer_1     = res_s12[1];
	assign numer_2     = res_s12[2];
	assign numer_3     = res_s12[3];
	assign denominator = res_s12[4];

endmodule

`default_nettype wire

>>> tb/quartic_inverse_prepare_tb.sv
`timescale 1ns / 100ps

module quartic_inverse_prepare_tb;

	typedef qip_pkg::coef_t coef_t;

	typedef struct packed {
		coef_t a0;
		coef_t a1;
		coef_t a2;
		coef_t a3;
		coef_t zeta;
	} elem_t;

	typedef struct packed {
		coef_t n0;
		coef_t n1;
		coef_t n2;
		coef_t n3;
		coef_t den;
	} inv_parts_t;

	typedef struct packed {
		elem_t      elem;
		logic       pinned;
		inv_parts_t want;
	} probe_row_t;

	localparam logic [15:0] NEG_QINV_LO = 16'hCD7F;
	localparam logic [31:0] MOD_Q       = 32'd3457;
	localparam int          IDLE_LIMIT  = 5000;
	localparam int          NUM_RANDOM  = 2000;
	localparam int          NUM_PROBES  = 20;

	localparam coef_t CMAX  = 16'sh7FFF;
	localparam coef_t CMIN  = 16'sh8000;
	localparam coef_t NEG1  = 16'shFFFF;
	localparam coef_t QPOS  = 16'sd3457;
	localparam coef_t QNEG  = -16'sd3457;
	localparam coef_t MONT1 = 16'sd3310;
	localparam coef_t HALF  = 16'sd16384;
	localparam coef_t PAT5  = 16'sh5555;
	localparam coef_t PATA  = 16'shAAAA;
	localparam inv_parts_t ALL_ZERO = '0;

	// An element with all coefficients zero reduces to zero everywhere, whatever the twist.
	localparam probe_row_t PROBES [NUM_PROBES] = '{
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, ALL_ZERO},
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, CMAX},   1'b1, ALL_ZERO},
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, CMIN},   1'b1, ALL_ZERO},
		'{'{CMAX, CMAX, CMAX, CMAX, CMAX},           1'b0, ALL_ZERO},
		'{'{CMIN, CMIN, CMIN, CMIN, CMIN},           1'b0, ALL_ZERO},
		'{'{CMIN, CMAX, CMIN, CMAX, CMAX},           1'b0, ALL_ZERO},
		'{'{CMAX, CMIN, CMAX, CMIN, CMIN},           1'b0, ALL_ZERO},
		'{'{NEG1, NEG1, NEG1, NEG1, NEG1},           1'b0, ALL_ZERO},
		'{'{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, ALL_ZERO},
		'{'{16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1}, 1'b0, ALL_ZERO},
		'{'{16'sd0, 16'sd0, 16'sd1, 16'sd0, NEG1},   1'b0, ALL_ZERO},
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd1, CMAX},   1'b0, ALL_ZERO},
		'{'{16'sd0, 16'sd0, 16'sd0, HALF, CMAX},     1'b0, ALL_ZERO},
		'{'{16'sd0, 16'sd0, CMIN, 16'sd0, 16'sd1},   1'b0, ALL_ZERO},
		'{'{QPOS, QNEG, QPOS, QNEG, QPOS},           1'b0, ALL_ZERO},
		'{'{PAT5, PATA, PAT5, PATA, PAT5},           1'b0, ALL_ZERO},
		'{'{PATA, PAT5, PATA, PAT5, PATA},           1'b0, ALL_ZERO},
		'{'{16'sd1000, 16'sd2000, -16'sd3000, 16'sd1500, MONT1}, 1'b0, ALL_ZERO},
		'{'{16'sd1, 16'sd0, 16'sd0, 16'sd0, MONT1},  1'b0, ALL_ZERO},
		'{'{QNEG, 16'sd1, 16'sd2, 16'sd3, QNEG},     1'b0, ALL_ZERO}
	};

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  in_valid  = 1'b0;
	logic  out_stall = 1'b0;
	coef_t coef_in_0 = '0;
	coef_t coef_in_1 = '0;
	coef_t coef_in_2 = '0;
	coef_t coef_in_3 = '0;
	coef_t twist     = '0;
	logic  in_stall;
	logic  out_valid;
	coef_t numer_0;
	coef_t numer_1;
	coef_t numer_2;
	coef_t numer_3;
	coef_t denominator;

	inv_parts_t  pending_parts [$];
	int          fail_count  = 0;
	int          idle_cycles = 0;
	int unsigned burst_left  = 0;
	int unsigned stall_mode  = 0;
	int unsigned mode_left   = 0;
	int unsigned stall_tick  = 0;

	quartic_inverse_prepare dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.coef_in_0   (coef_in_0),
		.coef_in_1   (coef_in_1),
		.coef_in_2   (coef_in_2),
		.coef_in_3   (coef_in_3),
		.twist       (twist),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.numer_0     (numer_0),
		.numer_1     (numer_1),
		.numer_2     (numer_2),
		.numer_3     (numer_3),
		.denominator (denominator)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] wide_mul(input coef_t a, input coef_t b);
		logic signed [31:0] p;
		p = 32'(a) * 32'(b);
		return p;
	endfunction

	// Signed Montgomery reduction; the quotient digit is sign extended before the fold.
	function automatic coef_t mont_reduce(input logic [31:0] x);
		logic [15:0] digit;
		logic [31:0] total;
		digit = x[15:0] * NEG_QINV_LO;
		total = x + {{16{digit[15]}}, digit} * MOD_Q;
		return total[31:16];
	endfunction

	function automatic coef_t negate(input coef_t v);
		logic [15:0] r;
		r = ~v + 16'd1;
		return r;
	endfunction

	function automatic coef_t neg_double(input coef_t v);
		logic [15:0] r;
		r = ~{v[14:0], 1'b0} + 16'd1;
		return r;
	endfunction

	function automatic inv_parts_t predict_inverse_parts(input elem_t e);
		coef_t      h0;
		coef_t      h1;
		coef_t      t0;
		coef_t      t1;
		coef_t      t2;
		inv_parts_t r;
		h0 = mont_reduce(wide_mul(e.a2, e.a2) + wide_mul(e.a1, neg_double(e.a3)));
		h1 = mont_reduce(wide_mul(e.a3, e.a3));
		t0 = mont_reduce(wide_mul(h0, e.zeta) + wide_mul(e.a0, e.a0));
		t1 = mont_reduce(wide_mul(h1, e.zeta) + wide_mul(e.a1, e.a1)
			+ wide_mul(e.a0, neg_double(e.a2)));
		t2 = mont_reduce(wide_mul(t1, e.zeta));
		r.den = mont_reduce(wide_mul(t0, t0) + wide_mul(negate(t1), t2));
		r.n0  = mont_reduce(wide_mul(e.a0, t0) + wide_mul(e.a2, t2));
		r.n1  = mont_reduce(wide_mul(e.a3, t2) + wide_mul(e.a1, t0));
		r.n2  = mont_reduce(wide_mul(e.a2, t0) + wide_mul(e.a0, t1));
		r.n3  = mont_reduce(wide_mul(e.a1, t1) + wide_mul(e.a3, t0));
		return r;
	endfunction

	// Mostly full-range patterns, some reduced values, some extremes.
	function automatic coef_t rand_coef();
		logic [31:0] raw;
		int          pick;
		int          v;
		raw  = $urandom;
		pick = $urandom_range(0, 99);
		v    = $urandom_range(0, 6912);
		v    = v - 3456;
		if (pick < 60) begin
			return raw[15:0];
		end else if (pick < 85) begin
			return 16'(v);
		end else begin
			case (raw[2:0])
				3'd0: return CMAX;
				3'd1: return CMIN;
				3'd2: return NEG1;
				3'd3: return 16'sd1;
				3'd4: return HALF;
				3'd5: return QNEG;
				default: return 16'sd0;
			endcase
		end
	endfunction

	task automatic check_field(input string name, input coef_t want, input coef_t got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Words go out in bursts; a gap with in_valid low opens each burst.
	task automatic send_word(input elem_t e, input logic pinned, input inv_parts_t want);
		int unsigned gap_len;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(100, 300);
			end else begin
				burst_left = $urandom_range(1, 24);
			end
			gap_len = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap_len) @(posedge clk);
		end
		burst_left--;
		in_valid  <= 1'b1;
		coef_in_0 <= e.a0;
		coef_in_1 <= e.a1;
		coef_in_2 <= e.a2;
		coef_in_3 <= e.a3;
		twist     <= e.zeta;
		do @(posedge clk); while (in_stall);
		pending_parts.push_back(pinned ? want : predict_inverse_parts(e));
	endtask

	initial begin
		elem_t e;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < NUM_PROBES; i++) begin
			send_word(PROBES[i].elem, PROBES[i].pinned, PROBES[i].want);
		end
		for (int i = 0; i < NUM_RANDOM; i++) begin
			e.a0   = rand_coef();
			e.a1   = rand_coef();
			e.a2   = rand_coef();
			e.a3   = rand_coef();
			e.zeta = rand_coef();
			send_word(e, 1'b0, ALL_ZERO);
		end
		in_valid <= 1'b0;
		while (pending_parts.size() != 0) @(posedge clk);
		repeat (qip_pkg::NumStages + 8) @(posedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// The receiver switches among free flow, light and heavy random stall and a fixed rhythm.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			mode_left  <= $urandom_range(30, 300);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 1) == 1);
			2: out_stall <= ($urandom_range(0, 99) < 85);
			default: out_stall <= ((stall_tick % 7) < 3);
		endcase
	end

	always @(posedge clk) begin
		inv_parts_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_parts.size() == 0) begin
				$error("result word with no expectation waiting");
				fail_count++;
			end else begin
				want = pending_parts.pop_front();
				check_field("numer_0", want.n0, numer_0);
				check_field("numer_1", want.n1, numer_1);
				check_field("numer_2", want.n2, numer_2);
				check_field("numer_3", want.n3, numer_3);
				check_field("denominator", want.den, denominator);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
